### hw/rtl/kpvk_pkg.sv
// ----------------------------------------------------------------------------
// kpvk_pkg
// Shared types and constants of the position/velocity key-travel filter:
// controller states, datapath operations, the command/status bundles and the
// configuration register map.
// ----------------------------------------------------------------------------
package kpvk_pkg;

    // Datapath word: all filter arithmetic wraps at 32 bits
    localparam int DATA_W     = 32;
    // Configuration port
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 3;
    // Velocity state is clamped to +/- a 16-bit limit, so 17 bits signed
    localparam int VEL_W      = 17;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_POS_NOISE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VEL_NOISE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MEAS_NOISE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_VAR_CAP    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_VEL_LIMIT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_VAR_START  = 3'd5;

    // Register reset values
    localparam logic [7:0]  RST_POS_NOISE  = 8'd1;
    localparam logic [7:0]  RST_VEL_NOISE  = 8'd4;
    localparam logic [11:0] RST_MEAS_NOISE = 12'd30;
    localparam logic [15:0] RST_VAR_CAP    = 16'd2000;
    localparam logic [15:0] RST_VEL_LIMIT  = 16'd25600;
    localparam logic [15:0] RST_VAR_START  = 16'd100;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_PREDICT,
        ST_DIVP_GO,
        ST_DIVP_WAIT,
        ST_DIVV_GO,
        ST_DIVV_WAIT,
        ST_MUL_KP,
        ST_MUL_KV,
        ST_MUL_PV,
        ST_MUL_VV,
        ST_FINISH,
        ST_DONE
    } state_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_PREDICT,
        OP_DIVP_GO,
        OP_TAKE_KP,
        OP_DIVV_GO,
        OP_TAKE_KV,
        OP_MUL_KP,
        OP_MUL_KV,
        OP_MUL_PV,
        OP_MUL_VV,
        OP_FINISH
    } op_t;

    // Controller to datapath
    typedef struct packed {
        op_t  op;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic started;
        logic div_done;
    } sts_t;

endpackage

### hw/rtl/kalman_pos_vel_key_filter_core.sv
// ----------------------------------------------------------------------------
// kalman_pos_vel_key_filter_core
// Position/velocity key-travel filter in fixed point, one sample at a time.
// ----------------------------------------------------------------------------
// Sequence: the first sample after reset only initialises the filter state;
//   every later sample runs prediction, the two 32-step divisions that share
//   one serial divider, and four shared-multiplier steps.
// Samples: a new sample is taken only once the previous one is through, but
//   while the previous result may still wait in the output register.
// Reset: synchronous active-low aresetn restores register defaults and the
//   unstarted state; the next sample loads the position.
module kalman_pos_vel_key_filter_core
    import kpvk_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_BITS-1:0] m_filtered
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    kpvk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Arithmetic and filter state
    kpvk_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_sample   (s_sample),
        .m_filtered (m_filtered),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

### hw/rtl/kpvk_div.sv
// ----------------------------------------------------------------------------
// kpvk_div
// Serial signed divider, one quotient bit per cycle. The divisor is always
// positive; the quotient is truncated toward zero.
// ----------------------------------------------------------------------------
module kpvk_div #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic         done
);

    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     den_reg, den_next;
    logic [W:0]       shifted;
    logic [W:0]       trial;

    // Restoring step: shift in the next dividend bit and try a subtract
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W - 1);
            neg_next  = dividend[W-1];
            quo_next  = dividend[W-1] ? (~dividend + W'(1)) : dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and partial result registers
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // Restore the sign of the quotient
    assign quotient = neg_reg ? (~quo_reg + W'(1)) : quo_reg;
    assign done     = done_reg;

    a_start_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_divisor_pos : assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (!divisor[W-1] && divisor != '0))
        else $error("divisor not positive");

    a_done_after_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

endmodule

### hw/rtl/kpvk_datapath.sv
// ----------------------------------------------------------------------------
// kpvk_datapath
// Filter state, configuration registers, one shared 32x32 multiplier and
// the serial divider. Each operation from the controller does one step of
// the predict/gain/correct sequence.
// ----------------------------------------------------------------------------
module kpvk_datapath
    import kpvk_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    output logic [SAMPLE_BITS-1:0] m_filtered,
    input  cmd_t                   cmd,
    output sts_t                   sts
);

    localparam int POS_W = SAMPLE_BITS + FRAC_BITS;
    localparam logic signed [DATA_W-1:0] FULL_Q =
        DATA_W'(((1 << SAMPLE_BITS) - 1) << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1 << FRAC_BITS);

    // Configuration
    logic [7:0]  pnoise_reg;
    logic [7:0]  vnoise_reg;
    logic [11:0] mnoise_reg;
    logic [15:0] cap_reg;
    logic [15:0] vlim_reg;
    logic [15:0] vstart_reg;

    // Filter state and working registers
    logic                     started_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [VEL_W-1:0]  vel_reg;
    logic signed [DATA_W-1:0] pv_reg;
    logic signed [DATA_W-1:0] vv_reg;
    logic [SAMPLE_BITS-1:0]   z_reg;
    logic signed [DATA_W-1:0] s_reg;
    logic signed [DATA_W-1:0] kp_reg;
    logic signed [DATA_W-1:0] kv_reg;
    logic signed [DATA_W-1:0] e_reg;
    logic signed [DATA_W-1:0] pos_tmp_reg;
    logic signed [DATA_W-1:0] prod_reg;
    logic [SAMPLE_BITS-1:0]   out_reg;

    logic signed [DATA_W-1:0] z_q;
    logic signed [DATA_W-1:0] pos_ext;
    logic signed [DATA_W-1:0] vel_ext;
    logic signed [DATA_W-1:0] pos_pred;
    logic signed [DATA_W-1:0] cap_s;
    logic signed [DATA_W-1:0] pv_grow;
    logic signed [DATA_W-1:0] vv_grow;
    logic signed [DATA_W-1:0] pv_cap;
    logic signed [DATA_W-1:0] vv_cap;
    logic signed [DATA_W-1:0] s_sum;
    logic signed [DATA_W-1:0] s_pos;
    logic signed [DATA_W-1:0] vlim_s;
    logic signed [DATA_W-1:0] prod_asr;
    logic signed [DATA_W-1:0] vel_sum;
    logic signed [DATA_W-1:0] vel_clamp;
    logic signed [DATA_W-1:0] pos_clamp;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [DATA_W-1:0] mul_lo;
    logic                     div_start;
    logic [DATA_W-1:0]        div_dividend;
    logic [DATA_W-1:0]        div_divisor;
    logic [DATA_W-1:0]        div_quotient;
    logic                     div_done;

    // Configuration writes; out-of-range indexes fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pnoise_reg <= RST_POS_NOISE;
            vnoise_reg <= RST_VEL_NOISE;
            mnoise_reg <= RST_MEAS_NOISE;
            cap_reg    <= RST_VAR_CAP;
            vlim_reg   <= RST_VEL_LIMIT;
            vstart_reg <= RST_VAR_START;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_POS_NOISE:  pnoise_reg <= cfg_wdata[7:0];
                CFG_VEL_NOISE:  vnoise_reg <= cfg_wdata[7:0];
                CFG_MEAS_NOISE: mnoise_reg <= cfg_wdata[11:0];
                CFG_VAR_CAP:    cap_reg    <= cfg_wdata;
                CFG_VEL_LIMIT:  vlim_reg   <= cfg_wdata;
                CFG_VAR_START:  vstart_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Prediction: position from velocity, variances grown and capped
    assign z_q      = DATA_W'(z_reg) << FRAC_BITS;
    assign pos_ext  = DATA_W'(pos_reg);
    assign vel_ext  = {{(DATA_W-VEL_W){vel_reg[VEL_W-1]}}, vel_reg};
    assign pos_pred = pos_ext + vel_ext;
    assign cap_s    = DATA_W'(cap_reg);
    assign pv_grow  = pv_reg + DATA_W'(pnoise_reg);
    assign vv_grow  = vv_reg + DATA_W'(vnoise_reg);
    assign pv_cap   = (pv_grow > cap_s) ? cap_s : pv_grow;
    assign vv_cap   = (vv_grow > cap_s) ? cap_s : vv_grow;

    // Gain divisor, forced to one when not positive
    assign s_sum = pv_reg + DATA_W'(mnoise_reg);
    assign s_pos = (s_sum <= 0) ? DATA_W'(1) : s_sum;

    // Divider operands: position gain first, then velocity gain
    assign div_start    = (cmd.op == OP_DIVP_GO) || (cmd.op == OP_DIVV_GO);
    assign div_dividend = (cmd.op == OP_DIVP_GO) ? (pv_reg <<< FRAC_BITS)
                                                 : (vv_reg <<< FRAC_BITS);
    assign div_divisor  = (cmd.op == OP_DIVP_GO) ? s_pos : s_reg;

    kpvk_div #(
        .W (DATA_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // Shared multiplier, low 32 bits of the product
    always_comb begin
        unique case (cmd.op)
            OP_MUL_KP: begin
                mul_a = kp_reg;
                mul_b = e_reg;
            end
            OP_MUL_KV: begin
                mul_a = kv_reg;
                mul_b = e_reg;
            end
            OP_MUL_PV: begin
                mul_a = ONE_Q - kp_reg;
                mul_b = pv_reg;
            end
            OP_MUL_VV: begin
                mul_a = ONE_Q - kv_reg;
                mul_b = vv_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_lo   = mul_a * mul_b;
    assign prod_asr = prod_reg >>> FRAC_BITS;

    // Velocity correction and symmetric clamp
    assign vlim_s    = DATA_W'(vlim_reg);
    assign vel_sum   = vel_ext + prod_asr;
    assign vel_clamp = (vel_sum > vlim_s)  ? vlim_s :
                       (vel_sum < -vlim_s) ? -vlim_s : vel_sum;

    // Position clamp to full scale
    assign pos_clamp = (pos_tmp_reg < 0)      ? '0     :
                       (pos_tmp_reg > FULL_Q) ? FULL_Q : pos_tmp_reg;

    // Filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
        end else if (cmd.op == OP_INIT) begin
            started_reg <= 1'b1;
        end
    end

    // Sequenced datapath steps
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                z_reg <= s_sample;
            end
            OP_INIT: begin
                pos_reg <= POS_W'(z_reg) << FRAC_BITS;
                vel_reg <= '0;
                pv_reg  <= DATA_W'(vstart_reg);
                vv_reg  <= DATA_W'(vstart_reg);
            end
            OP_PREDICT: begin
                pos_tmp_reg <= pos_pred;
                e_reg       <= z_q - pos_pred;
                pv_reg      <= pv_cap;
                vv_reg      <= vv_cap;
            end
            OP_DIVP_GO: begin
                s_reg <= s_pos;
            end
            OP_TAKE_KP: begin
                kp_reg <= div_quotient;
            end
            OP_TAKE_KV: begin
                kv_reg <= div_quotient;
            end
            OP_MUL_KP: begin
                prod_reg <= mul_lo;
            end
            OP_MUL_KV: begin
                pos_tmp_reg <= pos_tmp_reg + prod_asr;
                prod_reg    <= mul_lo;
            end
            OP_MUL_PV: begin
                vel_reg  <= vel_clamp[VEL_W-1:0];
                prod_reg <= mul_lo;
            end
            OP_MUL_VV: begin
                pv_reg   <= prod_asr;
                prod_reg <= mul_lo;
            end
            OP_FINISH: begin
                vv_reg  <= prod_asr;
                pos_reg <= pos_clamp[POS_W-1:0];
            end
            default: ;
        endcase
    end

    // Output data register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= pos_reg[FRAC_BITS +: SAMPLE_BITS];
        end
    end

    assign m_filtered   = out_reg;
    assign sts.started  = started_reg;
    assign sts.div_done = div_done;

    a_pos_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |-> (DATA_W'(pos_reg) <= FULL_Q))
        else $error("position estimate beyond full scale");

endmodule

### hw/rtl/kpvk_ctrl.sv
// ----------------------------------------------------------------------------
// kpvk_ctrl
// Sequencer of the filter: initialises the state on the first sample, then
// steps the datapath through prediction, the two gain divisions, the four
// multiplies and the final clamp, and owns the valid/ready handshakes.
// ----------------------------------------------------------------------------
module kpvk_ctrl
    import kpvk_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // Output register can take a result when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = sts.started ? ST_PREDICT : ST_INIT;
                end
            end
            ST_INIT:      state_next = ST_DONE;
            ST_PREDICT:   state_next = ST_DIVP_GO;
            ST_DIVP_GO:   state_next = ST_DIVP_WAIT;
            ST_DIVP_WAIT: begin
                if (sts.div_done) begin
                    state_next = ST_DIVV_GO;
                end
            end
            ST_DIVV_GO:   state_next = ST_DIVV_WAIT;
            ST_DIVV_WAIT: begin
                if (sts.div_done) begin
                    state_next = ST_MUL_KP;
                end
            end
            ST_MUL_KP:    state_next = ST_MUL_KV;
            ST_MUL_KV:    state_next = ST_MUL_PV;
            ST_MUL_PV:    state_next = ST_MUL_VV;
            ST_MUL_VV:    state_next = ST_FINISH;
            ST_FINISH:    state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:      cmd.op = s_valid ? OP_LOAD : OP_NONE;
            ST_INIT:      cmd.op = OP_INIT;
            ST_PREDICT:   cmd.op = OP_PREDICT;
            ST_DIVP_GO:   cmd.op = OP_DIVP_GO;
            ST_DIVP_WAIT: cmd.op = sts.div_done ? OP_TAKE_KP : OP_NONE;
            ST_DIVV_GO:   cmd.op = OP_DIVV_GO;
            ST_DIVV_WAIT: cmd.op = sts.div_done ? OP_TAKE_KV : OP_NONE;
            ST_MUL_KP:    cmd.op = OP_MUL_KP;
            ST_MUL_KV:    cmd.op = OP_MUL_KV;
            ST_MUL_PV:    cmd.op = OP_MUL_PV;
            ST_MUL_VV:    cmd.op = OP_MUL_VV;
            ST_FINISH:    cmd.op = OP_FINISH;
            ST_DONE:      cmd.out_load = out_free;
            default:      cmd.op = OP_NONE;
        endcase
    end

    // Result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    a_valid_from_done : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the completion state");

    a_busy_after_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready held high after accepting a sample");

    a_no_load_over_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && m_valid_reg) |-> m_ready)
        else $error("result overwritten before it was taken");

endmodule
